// ----- src/qwbd_pkg.sv -----
package qwbd_pkg;

    typedef logic [3:0] t_qt;

    localparam t_qt QT_F32  = 4'd0;
    localparam t_qt QT_F16  = 4'd1;
    localparam t_qt QT_BF16 = 4'd2;
    localparam t_qt QT_Q4_0 = 4'd3;
    localparam t_qt QT_Q4_1 = 4'd4;
    localparam t_qt QT_Q5_0 = 4'd5;
    localparam t_qt QT_Q5_1 = 4'd6;
    localparam t_qt QT_Q8_0 = 4'd7;
    localparam t_qt QT_Q4_K = 4'd8;
    localparam t_qt QT_Q6_K = 4'd9;

    localparam int BUF_DEPTH = 210;
    localparam int AW = $clog2(BUF_DEPTH);

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } t_buf_wr;

    typedef struct packed {
        logic push;
        t_qt  fmt;
    } t_blk_req;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_OP1,
        BK_OP2,
        BK_PUT
    } t_bk_state;

    // Bytes per block; zero for codes that name no format.
    function automatic logic [7:0] blk_bytes(t_qt qt);
        logic [7:0] n;
        unique case (qt)
            QT_F32:  n = 8'd4;
            QT_F16:  n = 8'd2;
            QT_BF16: n = 8'd2;
            QT_Q4_0: n = 8'd18;
            QT_Q4_1: n = 8'd20;
            QT_Q5_0: n = 8'd22;
            QT_Q5_1: n = 8'd24;
            QT_Q8_0: n = 8'd34;
            QT_Q4_K: n = 8'd144;
            QT_Q6_K: n = 8'd210;
            default: n = 8'd0;
        endcase
        return n;
    endfunction

    // Exact widening of an fp16 pattern; subnormals become fp32 normals.
    function automatic logic [31:0] half_to_f32(logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [19:0] sh;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        sh = {10'd0, man} << (4'd10 - p);
        if (ex == 5'd0) begin
            if (man == 10'd0) r = {h[15], 31'd0};
            else r = {h[15], 8'(8'd103 + {4'd0, p}), sh[9:0], 13'd0};
        end else if (ex == 5'd31) begin
            r = {h[15], 8'hFF, man, 13'd0};
        end else begin
            r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

endpackage

// ----- src/qwbd_if.sv -----
interface qwbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source(output valid, data_byte, restart, input ready);
    modport sink(input valid, data_byte, restart, output ready);
endinterface

interface qwbd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] value0;
    logic [31:0] value1;
    logic [31:0] value2;
    logic [31:0] value3;
    logic [7:0]  first_index;
    logic [2:0]  lanes_valid;
    logic        last;

    modport source(output valid, value0, value1, value2, value3, first_index,
                   lanes_valid, last, input ready);
    modport sink(input valid, value0, value1, value2, value3, first_index,
                 lanes_valid, last, output ready);
endinterface

// ----- src/quantized_weight_block_dequantizer.sv -----
// Channel  Dir  Payload                                         Handshake
// i_in     in   data_byte[7:0], restart                          valid/ready
// o_out    out  value0..value3[31:0], first_index[7:0],          valid/ready
//               lanes_valid[2:0], last
// i_cfg    in   i_cfg_data[3:0] (quant_type)                     i_cfg_we
//
// Bytes are taken one per cycle while a block fills. From a block's last byte
// until its last result is in the output register, i_in.ready is low.
// Each element takes 2 to 8 single-port buffer reads, then 0 to 4 fp operations,
// each split into BK_OP1 and BK_OP2; q4_k needs the most reads and operations.
// Reset is synchronous on i_rst_n; the block buffer is not cleared, since a
// block is only read after all of its bytes are written.
module quantized_weight_block_dequantizer #(
    parameter int LANES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    qwbd_byte_if.sink  i_in,
    qwbd_res_if.source o_out
);
    import qwbd_pkg::*;

    t_buf_wr       w_wr;
    t_blk_req      w_req;
    logic          w_pop, w_empty, w_done;
    t_qt           w_fmt;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    qwbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_done     (w_done),
        .o_wr       (w_wr),
        .o_req      (w_req)
    );

    qwbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_fmt   (w_fmt)
    );

    qwbd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qwbd_back #(
        .LANES (LANES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_fmt   (w_fmt),
        .o_q_pop   (w_pop),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata),
        .o_done    (w_done),
        .o_out     (o_out)
    );
endmodule

// ----- src/qwbd_ram.sv -----
module qwbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 210
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/qwbd_queue.sv -----
module qwbd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qwbd_pkg::t_blk_req  i_req,
    input  logic                i_pop,
    output logic                o_empty,
    output qwbd_pkg::t_qt       o_fmt
);
    import qwbd_pkg::*;

    t_qt        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_fmt   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_req.push && r_cnt != 2'd2) begin
                r_q[r_wp] <= i_req.fmt;
                r_wp      <= ~r_wp;
            end
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_req.push && r_cnt != 2'd2) - 2'(i_pop && !o_empty);
        end
    end
endmodule

// ----- src/qwbd_front.sv -----
module qwbd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data,
    qwbd_byte_if.sink           i_in,
    input  logic                i_done,
    output qwbd_pkg::t_buf_wr   o_wr,
    output qwbd_pkg::t_blk_req  o_req
);
    import qwbd_pkg::*;

    t_qt        r_qt;
    logic [7:0] r_pos;
    logic       r_hold;
    logic [7:0] w_size;
    logic [7:0] w_pos;
    logic       w_acc;
    logic       w_ok;

    assign i_in.ready = !r_hold;
    assign w_acc      = i_in.valid && !r_hold;
    assign w_size     = blk_bytes(r_qt);
    assign w_ok       = (w_size != 8'd0);

    always_comb begin
        w_pos = i_in.restart ? 8'd0 : r_pos;
        if (w_pos >= w_size) w_pos = 8'd0;
    end

    assign o_wr.we    = w_acc && w_ok;
    assign o_wr.addr  = w_pos[AW-1:0];
    assign o_wr.data  = i_in.data_byte;
    assign o_req.push = w_acc && w_ok && (w_pos + 8'd1 == w_size);
    assign o_req.fmt  = r_qt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qt   <= QT_F32;
            r_pos  <= 8'd0;
            r_hold <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qt  <= i_cfg_data;
                r_pos <= 8'd0;
            end else if (w_acc) begin
                if (!w_ok || o_req.push) r_pos <= 8'd0;
                else r_pos <= w_pos + 8'd1;
            end
            // The buffer stays closed from a block's last byte until the
            // back end has read its last element.
            if (o_req.push) r_hold <= 1'b1;
            else if (i_done) r_hold <= 1'b0;
        end
    end
endmodule

// ----- src/qwbd_back.sv -----
module qwbd_back #(
    parameter int LANES = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  qwbd_pkg::t_qt           i_q_fmt,
    output logic                    o_q_pop,
    output logic [qwbd_pkg::AW-1:0] o_raddr,
    input  logic [7:0]              i_rdata,
    output logic                    o_done,
    qwbd_res_if.source              o_out
);
    import qwbd_pkg::*;

    localparam int LN = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);
    localparam logic [1:0] LAST_LANE = 2'(LN - 1);

    t_bk_state r_st, n_st;
    t_qt         r_fmt;
    logic [7:0]  r_e;
    logic [2:0]  r_k, r_capk;
    logic        r_cap;
    logic [7:0]  r_b [8];
    logic [1:0]  r_op;
    logic [31:0] r_t, r_m1;
    logic [1:0]  r_lane;
    logic [31:0] r_vals [4];

    logic [47:0]       r_mp;
    logic signed [9:0] r_me;
    logic              r_msg, r_msp;
    logic [31:0]       r_msv;
    logic [27:0]       r_asum;
    logic [7:0]        r_ae;
    logic              r_asg, r_asp;
    logic [31:0]       r_asv;

    logic        r_ov;
    logic [31:0] r_ovals [4];
    logic [7:0]  r_ofirst;
    logic [2:0]  r_olanes;
    logic        r_olast;

    // Byte address of read slot k for element e.
    function automatic logic [7:0] slot_addr(t_qt f, logic [7:0] e, logic [2:0] k);
        logic [7:0] a;
        logic [7:0] kk;
        kk = {5'd0, k};
        a  = kk;
        case (f)
            QT_Q4_0: if (k >= 3'd2) a = 8'd2 + {4'd0, e[3:0]};
            QT_Q4_1: if (k >= 3'd4) a = 8'd4 + {4'd0, e[3:0]};
            QT_Q5_0: begin
                if (k == 3'd2) a = 8'd6 + {4'd0, e[3:0]};
                else if (k == 3'd3) a = 8'd2 + {6'd0, e[4:3]};
            end
            QT_Q5_1: begin
                if (k == 3'd4) a = 8'd8 + {4'd0, e[3:0]};
                else if (k == 3'd5) a = 8'd4 + {6'd0, e[4:3]};
            end
            QT_Q8_0: if (k >= 3'd2) a = 8'd2 + {3'd0, e[4:0]};
            QT_Q4_K: begin
                if (k == 3'd4) a = 8'd16 + {1'b0, e[7:6], e[4:0]};
                else if (k == 3'd5) a = 8'd4 + {5'd0, e[7:5]};
                else if (k == 3'd6) a = 8'd8 + {5'd0, e[7:5]};
                else if (k == 3'd7) a = {5'd0, e[7:5]};
            end
            QT_Q6_K: begin
                case (k)
                    3'd0: a = 8'd208;
                    3'd1: a = 8'd209;
                    3'd2: a = {1'b0, e[7], e[5], e[4:0]};
                    3'd3: a = 8'd128 + {2'd0, e[7], e[4:0]};
                    default: a = 8'd192 + {4'd0, e[7], e[6:5], e[4]};
                endcase
            end
            default: a = kk;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] last_slot(t_qt f);
        logic [2:0] n;
        case (f)
            QT_F32:  n = 3'd3;
            QT_Q4_0: n = 3'd2;
            QT_Q4_1: n = 3'd4;
            QT_Q5_0: n = 3'd3;
            QT_Q5_1: n = 3'd5;
            QT_Q8_0: n = 3'd2;
            QT_Q4_K: n = 3'd7;
            QT_Q6_K: n = 3'd4;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] int_to_f32(logic signed [8:0] v);
        logic [8:0]  mag;
        logic [2:0]  p;
        logic [31:0] sh;
        mag = v[8] ? 9'(-v) : v;
        p   = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) p = 3'(i);
        end
        sh = {23'd0, mag} << (5'd23 - {2'd0, p});
        if (mag == 9'd0) return 32'd0;
        return {v[8], 8'(8'd127 + {5'd0, p}), sh[22:0]};
    endfunction

    // ---------------- operand decode ----------------
    logic [31:0]       w_d, w_m;
    logic signed [8:0] w_iq, w_isc, w_imn;
    logic [3:0]        w_nib;
    logic [2:0]        w_j;
    logic [1:0]        w_nops;

    assign w_d = half_to_f32({r_b[1], r_b[0]});
    assign w_m = half_to_f32({r_b[3], r_b[2]});
    assign w_j = r_e[7:5];

    always_comb begin
        w_iq  = 9'sd0;
        w_isc = 9'sd0;
        w_imn = 9'sd0;
        w_nib = r_e[4] ? r_b[2][7:4] : r_b[2][3:0];
        case (r_fmt)
            QT_Q4_0: w_iq = $signed({5'd0, w_nib}) - 9'sd8;
            QT_Q4_1: begin
                w_nib = r_e[4] ? r_b[4][7:4] : r_b[4][3:0];
                w_iq  = $signed({5'd0, w_nib});
            end
            QT_Q5_0: w_iq = $signed({4'd0, r_b[3][r_e[2:0]], w_nib}) - 9'sd16;
            QT_Q5_1: begin
                w_nib = r_e[4] ? r_b[4][7:4] : r_b[4][3:0];
                w_iq  = $signed({4'd0, r_b[5][r_e[2:0]], w_nib});
            end
            QT_Q8_0: w_iq = $signed({r_b[2][7], r_b[2]});
            QT_Q4_K: begin
                w_nib = r_e[5] ? r_b[4][7:4] : r_b[4][3:0];
                w_iq  = $signed({5'd0, w_nib});
                if (!w_j[2]) begin
                    w_isc = $signed({3'd0, r_b[5][5:0]});
                    w_imn = $signed({3'd0, r_b[6][5:0]});
                end else begin
                    w_isc = $signed({3'd0, r_b[7][7:6], r_b[6][3:0]});
                    w_imn = $signed({3'd0, r_b[5][7:6], r_b[6][7:4]});
                end
            end
            QT_Q6_K: begin
                w_nib = r_e[6] ? r_b[2][7:4] : r_b[2][3:0];
                w_iq  = $signed({3'd0, 2'(r_b[3] >> {r_e[6:5], 1'b0}), w_nib})
                        - 9'sd32;
                w_isc = $signed({r_b[4][7], r_b[4]});
            end
            default: w_iq = 9'sd0;
        endcase
    end

    always_comb begin
        case (r_fmt)
            QT_Q4_0, QT_Q5_0, QT_Q8_0: w_nops = 2'd0;
            QT_Q4_1, QT_Q5_1, QT_Q6_K: w_nops = 2'd1;
            QT_Q4_K:                   w_nops = 2'd3;
            default:                   w_nops = 2'd0;
        endcase
    end

    logic w_has_ops;
    assign w_has_ops = (r_fmt >= QT_Q4_0) && (r_fmt <= QT_Q6_K);

    // Operation r_op: a multiply by a small integer or an add.
    logic              w_add, w_to_m1;
    logic [31:0]       w_opa, w_opb, w_addend;
    logic signed [8:0] w_int;

    always_comb begin
        w_add    = 1'b0;
        w_to_m1  = 1'b0;
        w_opa    = w_d;
        w_int    = w_iq;
        w_addend = w_m;
        case (r_fmt)
            QT_Q4_1, QT_Q5_1: begin
                if (r_op != 2'd0) begin
                    w_add = 1'b1;
                    w_opa = r_t;
                end
            end
            QT_Q4_K: begin
                case (r_op)
                    2'd0: w_int = w_isc;
                    2'd1: begin
                        w_opa   = w_m;
                        w_int   = w_imn;
                        w_to_m1 = 1'b1;
                    end
                    2'd2: w_opa = r_t;
                    default: begin
                        w_add    = 1'b1;
                        w_opa    = r_t;
                        w_addend = {~r_m1[31], r_m1[30:0]};
                    end
                endcase
            end
            QT_Q6_K: begin
                if (r_op == 2'd0) w_int = w_isc;
                else w_opa = r_t;
            end
            default: w_add = 1'b0;
        endcase
        w_opb = w_add ? w_addend : int_to_f32(w_int);
    end

    // ---------------- fp multiply / add, first half ----------------
    logic [7:0] w_ea, w_eb;
    logic       w_an, w_bn, w_ai, w_bi, w_az, w_bz;

    assign w_ea = w_opa[30:23];
    assign w_eb = w_opb[30:23];
    assign w_an = (&w_ea) && (|w_opa[22:0]);
    assign w_bn = (&w_eb) && (|w_opb[22:0]);
    assign w_ai = (&w_ea) && !(|w_opa[22:0]);
    assign w_bi = (&w_eb) && !(|w_opb[22:0]);
    assign w_az = (w_ea == 8'd0);
    assign w_bz = (w_eb == 8'd0);

    logic        w_msg, w_msp;
    logic [31:0] w_msv;

    assign w_msg = w_opa[31] ^ w_opb[31];
    assign w_msp = w_an | w_bn | w_ai | w_bi | w_az | w_bz;

    always_comb begin
        if (w_an || w_bn || (w_ai && w_bz) || (w_bi && w_az)) w_msv = CANON_NAN;
        else if (w_ai || w_bi) w_msv = {w_msg, 8'hFF, 23'd0};
        else w_msv = {w_msg, 31'd0};
    end

    logic        w_asp, w_swap;
    logic [31:0] w_asv, w_x, w_y;
    logic [7:0]  w_dif;
    logic [26:0] w_mx, w_my, w_mys;
    logic [53:0] w_sh;
    logic [27:0] w_sum;

    always_comb begin
        w_asp = w_an | w_bn | w_ai | w_bi | w_az | w_bz;
        if (w_an || w_bn || (w_ai && w_bi && (w_opa[31] != w_opb[31]))) w_asv = CANON_NAN;
        else if (w_ai) w_asv = w_opa;
        else if (w_bi) w_asv = w_opb;
        else if (w_az && w_bz) w_asv = {w_opa[31] & w_opb[31], 31'd0};
        else if (w_az) w_asv = w_opb;
        else w_asv = w_opa;
        w_swap = (w_opa[30:0] < w_opb[30:0]);
        w_x    = w_swap ? w_opb : w_opa;
        w_y    = w_swap ? w_opa : w_opb;
        w_dif  = w_x[30:23] - w_y[30:23];
        w_mx   = {1'b1, w_x[22:0], 3'd0};
        w_my   = {1'b1, w_y[22:0], 3'd0};
        w_sh   = {w_my, 27'd0} >> w_dif;
        // Bits shifted past the guard positions fold into the sticky bit.
        if (w_dif > 8'd27) w_mys = 27'd1;
        else w_mys = {w_sh[53:28], w_sh[27] | (|w_sh[26:0])};
        if (w_x[31] != w_y[31]) w_sum = {1'b0, w_mx} - {1'b0, w_mys};
        else w_sum = {1'b0, w_mx} + {1'b0, w_mys};
    end

    // ---------------- second half: normalize and round ----------------
    logic [22:0]       w_mm;
    logic              w_mg, w_mst, w_minc;
    logic signed [9:0] w_mex, w_mex2;
    logic [23:0]       w_mr;
    logic [31:0]       w_mres;

    always_comb begin
        if (r_mp[47]) begin
            w_mm  = r_mp[46:24];
            w_mg  = r_mp[23];
            w_mst = |r_mp[22:0];
            w_mex = r_me + 10'sd1;
        end else begin
            w_mm  = r_mp[45:23];
            w_mg  = r_mp[22];
            w_mst = |r_mp[21:0];
            w_mex = r_me;
        end
        w_minc = w_mg & (w_mst | w_mm[0]);
        w_mr   = {1'b0, w_mm} + {23'd0, w_minc};
        w_mex2 = w_mex + $signed({9'd0, w_mr[23]});
        if (r_msp) w_mres = r_msv;
        else if (w_mex2 >= 10'sd255) w_mres = {r_msg, 8'hFF, 23'd0};
        else if (w_mex2 <= 10'sd0) w_mres = {r_msg, 31'd0};
        else w_mres = {r_msg, w_mex2[7:0], w_mr[22:0]};
    end

    logic [4:0]        w_lz;
    logic [26:0]       w_n;
    logic signed [9:0] w_aex, w_aex2;
    logic              w_ainc;
    logic [23:0]       w_ar;
    logic [31:0]       w_ares;

    always_comb begin
        w_lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r_asum[i]) w_lz = 5'(26 - i);
        end
        if (r_asum[27]) begin
            w_n   = {r_asum[27:2], |r_asum[1:0]};
            w_aex = $signed({2'd0, r_ae}) + 10'sd1;
        end else begin
            w_n   = r_asum[26:0] << w_lz;
            w_aex = $signed({2'd0, r_ae}) - $signed({5'd0, w_lz});
        end
        w_ainc = w_n[2] & ((|w_n[1:0]) | w_n[3]);
        w_ar   = {1'b0, w_n[25:3]} + {23'd0, w_ainc};
        w_aex2 = w_aex + $signed({9'd0, w_ar[23]});
        if (r_asp) w_ares = r_asv;
        else if (r_asum == 28'd0) w_ares = 32'd0;
        else if (w_aex2 >= 10'sd255) w_ares = {r_asg, 8'hFF, 23'd0};
        else if (w_aex2 <= 10'sd0) w_ares = {r_asg, 31'd0};
        else w_ares = {r_asg, w_aex2[7:0], w_ar[22:0]};
    end

    // ---------------- element value and lane collection ----------------
    logic [31:0] w_raw, w_val;
    logic [7:0]  w_last_e;
    logic        w_elast, w_gend, w_free, w_load, w_adv;
    logic [31:0] w_vals [4];

    always_comb begin
        case (r_fmt)
            QT_F32:  w_raw = {r_b[3], r_b[2], r_b[1], r_b[0]};
            QT_F16:  w_raw = w_d;
            QT_BF16: w_raw = {r_b[1], r_b[0], 16'd0};
            default: w_raw = r_t;
        endcase
        if ((&w_raw[30:23]) && (|w_raw[22:0])) w_val = CANON_NAN;
        else w_val = w_raw;
        case (r_fmt)
            QT_Q4_K, QT_Q6_K: w_last_e = 8'd255;
            QT_F32, QT_F16, QT_BF16: w_last_e = 8'd0;
            default: w_last_e = 8'd31;
        endcase
        w_vals         = r_vals;
        w_vals[r_lane] = w_val;
    end

    assign w_elast = (r_e == w_last_e);
    assign w_gend  = w_elast || (r_lane == LAST_LANE);
    assign w_free  = !r_ov || o_out.ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE: if (!i_q_empty) n_st = BK_READ;
            BK_READ: if (r_k == last_slot(r_fmt)) n_st = BK_WAIT;
            BK_WAIT: n_st = w_has_ops ? BK_OP1 : BK_PUT;
            BK_OP1:  n_st = BK_OP2;
            BK_OP2:  n_st = (r_op == w_nops) ? BK_PUT : BK_OP1;
            BK_PUT: begin
                if (!w_gend) n_st = BK_READ;
                else if (w_free) n_st = w_elast ? BK_IDLE : BK_READ;
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == BK_IDLE) && !i_q_empty;
        o_raddr = slot_addr(r_fmt, r_e, r_k)[AW-1:0];
        w_adv   = (r_st == BK_PUT) && (!w_gend || w_free);
        w_load  = (r_st == BK_PUT) && w_gend && w_free;
        o_done  = w_load && w_elast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= BK_IDLE;
            r_cap <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cap <= (r_st == BK_READ);
            if (w_load) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_capk <= r_k;
        if (r_cap) r_b[r_capk] <= i_rdata;
        if (o_q_pop) begin
            r_fmt  <= i_q_fmt;
            r_e    <= 8'd0;
            r_k    <= 3'd0;
            r_lane <= 2'd0;
            for (int i = 0; i < 4; i++) r_vals[i] <= 32'd0;
        end
        if (r_st == BK_READ) r_k <= r_k + 3'd1;
        if (r_st == BK_WAIT) r_op <= 2'd0;
        if (r_st == BK_OP1) begin
            r_mp   <= {1'b1, w_opa[22:0]} * {1'b1, w_opb[22:0]};
            r_me   <= $signed({2'd0, w_ea}) + $signed({2'd0, w_eb}) - 10'sd127;
            r_msg  <= w_msg;
            r_msp  <= w_msp;
            r_msv  <= w_msv;
            r_asum <= w_sum;
            r_ae   <= w_x[30:23];
            r_asg  <= w_x[31];
            r_asp  <= w_asp;
            r_asv  <= w_asv;
        end
        if (r_st == BK_OP2) begin
            r_op <= r_op + 2'd1;
            if (w_to_m1) r_m1 <= w_mres;
            else r_t <= w_add ? w_ares : w_mres;
        end
        if (w_adv) begin
            r_e <= r_e + 8'd1;
            r_k <= 3'd0;
            if (w_gend) begin
                r_lane <= 2'd0;
                for (int i = 0; i < 4; i++) r_vals[i] <= 32'd0;
            end else begin
                r_lane         <= r_lane + 2'd1;
                r_vals[r_lane] <= w_val;
            end
        end
        if (w_load) begin
            r_ovals  <= w_vals;
            r_ofirst <= r_e - {6'd0, r_lane};
            r_olanes <= {1'b0, r_lane} + 3'd1;
            r_olast  <= w_elast;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.value0      = r_ovals[0];
    assign o_out.value1      = r_ovals[1];
    assign o_out.value2      = r_ovals[2];
    assign o_out.value3      = r_ovals[3];
    assign o_out.first_index = r_ofirst;
    assign o_out.lanes_valid = r_olanes;
    assign o_out.last        = r_olast;
endmodule

// ----- verif/qwbd_scoreboard.sv -----
`timescale 1ns / 100ps

module qwbd_scoreboard
    import qwbd_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    qwbd_byte_if       in_ch,
    qwbd_res_if        out_ch,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);

    typedef struct packed {
        logic [3:0][31:0] vals;
        logic [7:0]       first;
        logic [2:0]       lanes;
        logic             last;
    } t_row;

    t_row       rows_due[$];
    logic [7:0] blk[BUF_DEPTH];
    int         fill;
    t_qt        fmt;

    function automatic int fmt_bytes(t_qt q);
        case (q)
            QT_F32:  return 4;
            QT_F16:  return 2;
            QT_BF16: return 2;
            QT_Q4_0: return 18;
            QT_Q4_1: return 20;
            QT_Q5_0: return 22;
            QT_Q5_1: return 24;
            QT_Q8_0: return 34;
            QT_Q4_K: return 144;
            QT_Q6_K: return 210;
            default: return 0;
        endcase
    endfunction

    // Rounds sig * 2^e to fp32 with round to nearest even, subnormals included.
    function automatic logic [31:0] fp_round(logic s, int e, logic [63:0] sig);
        int         p;
        int         ex;
        int         sh;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] hlf;
        longint     r;
        if (sig == 64'd0) return {s, 31'd0};
        p = 0;
        for (int i = 0; i < 64; i++) if (sig[i]) p = i;
        ex = e + p + 127;
        sh = p - 23;
        if (ex < 1) sh = sh + 1 - ex;
        if (sh > 63) begin
            m = 64'd0;
        end else if (sh > 0) begin
            m   = sig >> sh;
            rem = sig & ((64'd1 << sh) - 64'd1);
            hlf = 64'd1 << (sh - 1);
            if (rem > hlf || (rem == hlf && m[0])) m = m + 64'd1;
        end else begin
            m = sig << (-sh);
        end
        if (ex >= 1) r = (longint'(ex - 1) << 23) + longint'(m);
        else r = longint'(m);
        if (r >= 64'h7F80_0000) r = 64'h7F80_0000;
        return {s, r[30:0]};
    endfunction

    function automatic logic is_nan(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(logic [31:0] a);
        return a[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic [23:0] sig_of(logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic int exp_of(logic [31:0] a);
        return (a[30:23] == 8'd0 ? 1 : int'(a[30:23])) - 150;
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
            return CANON_NAN;
        if (is_inf(a) || is_inf(b)) return {s, 31'h7F80_0000};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
        return fp_round(s, exp_of(a) + exp_of(b), 64'(sig_of(a)) * 64'(sig_of(b)));
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        logic [63:0] big;
        logic [63:0] sml;
        logic [63:0] lost;
        int          d;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        if (a[30:0] < b[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        d   = exp_of(a) - exp_of(b);
        big = 64'(sig_of(a)) << 30;
        sml = 64'(sig_of(b)) << 30;
        // Bits shifted out of the smaller operand collapse into a sticky bit.
        if (d > 60) begin
            sml = 64'd1;
        end else begin
            lost = sml & ((64'd1 << d) - 64'd1);
            sml  = (sml >> d) | 64'(lost != 64'd0);
        end
        if (a[31] == b[31]) return fp_round(a[31], exp_of(a) - 30, big + sml);
        if (big == sml) return 32'd0;
        return fp_round(a[31], exp_of(a) - 30, big - sml);
    endfunction

    function automatic logic [31:0] int_to_fp(int x);
        return fp_round(x < 0, 0, 64'(x < 0 ? -x : x));
    endfunction

    function automatic logic [31:0] widen_half(logic [15:0] h);
        logic [10:0] mm;
        int          sh;
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) return {h[15], 31'd0};
            mm = {1'b0, h[9:0]};
            sh = 0;
            while (!mm[10]) begin
                mm = mm << 1;
                sh++;
            end
            return {h[15], 8'(113 - sh), mm[9:0], 13'd0};
        end
        if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
        return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
    endfunction

    function automatic logic [15:0] half_at(int o);
        return {blk[o + 1], blk[o]};
    endfunction

    function automatic int sbyte(logic [7:0] b);
        return int'(b) - (b[7] ? 256 : 0);
    endfunction

    // Value of element e of the buffered block as an fp32 pattern.
    function automatic logic [31:0] dequant(int e);
        logic [31:0] d;
        logic [31:0] mn;
        logic [31:0] t;
        logic [31:0] r;
        logic [31:0] qh;
        logic [7:0]  b;
        int          q;
        int          chunk;
        int          sub;
        int          lo;
        int          j;
        int          sc;
        int          mv;
        int          hf;
        int          g;
        lo = e % 32;
        case (fmt)
            QT_F32:  r = {blk[3], blk[2], blk[1], blk[0]};
            QT_F16:  r = widen_half(half_at(0));
            QT_BF16: r = {half_at(0), 16'd0};
            QT_Q4_0: begin
                b = blk[2 + e % 16];
                q = e < 16 ? b[3:0] : b[7:4];
                r = fp_mul(int_to_fp(q - 8), widen_half(half_at(0)));
            end
            QT_Q4_1: begin
                b = blk[4 + e % 16];
                q = e < 16 ? b[3:0] : b[7:4];
                t = fp_mul(int_to_fp(q), widen_half(half_at(0)));
                r = fp_add(t, widen_half(half_at(2)));
            end
            QT_Q5_0: begin
                b  = blk[6 + e % 16];
                qh = {blk[5], blk[4], blk[3], blk[2]};
                q  = (e < 16 ? b[3:0] : b[7:4]) + (qh[lo] ? 16 : 0);
                r  = fp_mul(int_to_fp(q - 16), widen_half(half_at(0)));
            end
            QT_Q5_1: begin
                b  = blk[8 + e % 16];
                qh = {blk[7], blk[6], blk[5], blk[4]};
                q  = (e < 16 ? b[3:0] : b[7:4]) + (qh[lo] ? 16 : 0);
                t  = fp_mul(int_to_fp(q), widen_half(half_at(0)));
                r  = fp_add(t, widen_half(half_at(2)));
            end
            QT_Q8_0: r = fp_mul(int_to_fp(sbyte(blk[2 + lo])), widen_half(half_at(0)));
            QT_Q4_K: begin
                chunk = (e / 64) % 4;
                sub   = (e / 32) % 2;
                j     = 2 * chunk + sub;
                // Six-bit scales and mins; the upper four share their top bits.
                if (j < 4) begin
                    sc = blk[4 + j] & 63;
                    mv = blk[8 + j] & 63;
                end else begin
                    sc = (blk[j + 8] & 15) | ((blk[j] >> 6) << 4);
                    mv = (blk[j + 8] >> 4) | ((blk[j + 4] >> 6) << 4);
                end
                b  = blk[16 + 32 * chunk + lo];
                q  = sub ? b[7:4] : b[3:0];
                d  = fp_mul(widen_half(half_at(0)), int_to_fp(sc));
                mn = fp_mul(widen_half(half_at(2)), int_to_fp(mv));
                t  = fp_mul(d, int_to_fp(q));
                r  = fp_add(t, {~mn[31], mn[30:0]});
            end
            QT_Q6_K: begin
                hf = (e / 128) % 2;
                g  = (e / 32) % 4;
                b  = blk[64 * hf + lo + (g % 2 == 1 ? 32 : 0)];
                q  = g < 2 ? b[3:0] : b[7:4];
                q  = q | (((blk[128 + 32 * hf + lo] >> (2 * g)) & 3) << 4);
                t  = fp_mul(widen_half(half_at(208)),
                            int_to_fp(sbyte(blk[192 + 8 * hf + lo / 16 + 2 * g])));
                r  = fp_mul(t, int_to_fp(q - 32));
            end
            default: r = 32'd0;
        endcase
        if (is_nan(r)) r = CANON_NAN;
        return r;
    endfunction

    function automatic int lane_width();
        return LANES < 1 ? 1 : (LANES > 4 ? 4 : LANES);
    endfunction

    task automatic take_byte(logic [7:0] data, logic rs);
        int   size;
        int   nel;
        int   w;
        t_row row;
        if (rs) fill = 0;
        size = fmt_bytes(fmt);
        if (size == 0) begin
            fill = 0;
            return;
        end
        if (fill >= size) fill = 0;
        blk[fill] = data;
        fill++;
        if (fill < size) return;
        fill = 0;
        nel = size <= 4 ? 1 : (size >= 144 ? 256 : 32);
        w   = lane_width();
        for (int f = 0; f < nel; f += w) begin
            row.lanes = 3'((nel - f) < w ? nel - f : w);
            for (int k = 0; k < 4; k++) row.vals[k] = k < row.lanes ? dequant(f + k) : 32'd0;
            row.first = 8'(f);
            row.last  = f + row.lanes >= nel;
            rows_due.push_back(row);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_row want;
        if (!i_rst_n) begin
            fmt  = QT_F32;
            fill = 0;
            rows_due.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                o_results++;
                if (rows_due.size() == 0) begin
                    report("unexpected result", 32'(out_ch.first_index), 32'd0);
                end else begin
                    want = rows_due.pop_front();
                    if (out_ch.value0 !== want.vals[0]) report("value0", out_ch.value0, want.vals[0]);
                    if (out_ch.value1 !== want.vals[1]) report("value1", out_ch.value1, want.vals[1]);
                    if (out_ch.value2 !== want.vals[2]) report("value2", out_ch.value2, want.vals[2]);
                    if (out_ch.value3 !== want.vals[3]) report("value3", out_ch.value3, want.vals[3]);
                    if (out_ch.first_index !== want.first)
                        report("first_index", 32'(out_ch.first_index), 32'(want.first));
                    if (out_ch.lanes_valid !== want.lanes)
                        report("lanes_valid", 32'(out_ch.lanes_valid), 32'(want.lanes));
                    if (out_ch.last !== want.last)
                        report("last", 32'(out_ch.last), 32'(want.last));
                end
            end
            if (i_cfg_we) begin
                fmt  = i_cfg_data;
                fill = 0;
            end
            if (in_ch.valid && in_ch.ready) take_byte(in_ch.data_byte, in_ch.restart);
        end
        o_pending = rows_due.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import qwbd_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  HOLD_CYCLES = 600;
    localparam t_qt QT_BAD_TOP  = 4'd15;
    localparam t_qt QT_BAD_LOW  = 4'd10;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;
    int         cycles = 0;
    int         bytes_sent = 0;
    int         burst_left = 0;
    logic       hold_go = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;
    int         errors;
    int         pending;
    int         results;
    int         block_len[10] = '{4, 2, 2, 18, 20, 22, 24, 34, 144, 210};

    qwbd_byte_if in_if();
    qwbd_res_if  out_if();

    quantized_weight_block_dequantizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    qwbd_scoreboard u_scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_if),
        .out_ch     (out_if),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver steps through four stall patterns, from always ready to rarely ready;
    // once it also holds off long enough for the block to back up into its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else if (hold_go && !hold_done) begin
            out_if.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            case ((cycles / 64) % 4)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                2:       out_if.ready <= $urandom_range(0, 1);
                default: out_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic put_byte(logic [7:0] data, logic rs);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.data_byte <= data;
        in_if.restart   <= rs;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_format(t_qt q);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= q;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One block with random content; sometimes preceded by a broken one that
    // the restart of the real block has to drop.
    task automatic send_block(t_qt q);
        int  size;
        int  cut;
        logic rs;
        size = (q > QT_Q6_K) ? 6 : block_len[q];
        rs   = ($urandom_range(0, 2) == 0);
        if (size > 1 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, size - 1);
            for (int i = 0; i < cut; i++) put_byte($urandom_range(0, 255), i == 0 && rs);
            rs = 1'b1;
        end
        for (int i = 0; i < size; i++)
            put_byte($urandom_range(0, 255), (i == 0 && rs) || $urandom_range(0, 299) == 0);
    endtask

    initial begin
        t_qt order[12];
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'd0;
        in_if.restart   = 1'b0;
        out_if.ready    = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = 4'd0;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // f32 at reset: a signaling NaN, then a partial word dropped by restart.
        put_byte(8'h01, 1'b0); put_byte(8'h00, 1'b0);
        put_byte(8'h80, 1'b0); put_byte(8'h7F, 1'b0);
        put_byte(8'hAA, 1'b0); put_byte(8'hBB, 1'b0);
        put_byte(8'hFF, 1'b1); put_byte(8'hFF, 1'b0);
        put_byte(8'h7F, 1'b0); put_byte(8'hFF, 1'b0);
        set_format(QT_F16);
        put_byte(8'h01, 1'b0); put_byte(8'h80, 1'b0);
        put_byte(8'h00, 1'b0); put_byte(8'h7C, 1'b0);
        put_byte(8'hFF, 1'b0); put_byte(8'h03, 1'b0);
        set_format(QT_BF16);
        put_byte(8'h01, 1'b0);
        // A configuration write must discard the byte already taken.
        set_format(QT_BF16);
        put_byte(8'hC1, 1'b0); put_byte(8'hFF, 1'b0);
        set_format(QT_BAD_TOP);
        put_byte(8'h00, 1'b0); put_byte(8'hFF, 1'b1);

        order = '{QT_Q4_0, QT_Q4_1, QT_Q5_0, QT_Q5_1, QT_Q8_0, QT_Q4_K,
                  QT_Q6_K, QT_F32, QT_F16, QT_BF16, QT_BAD_LOW, QT_Q8_0};
        foreach (order[p]) begin
            set_format(order[p]);
            if (p == 4) hold_go <= 1'b1;
            if (order[p] >= QT_Q4_K && order[p] <= QT_Q6_K) begin
                send_block(order[p]);
            end else begin
                repeat (order[p] <= QT_BF16 || order[p] > QT_Q6_K ? 6 : 2)
                    send_block(order[p]);
            end
        end
        set_format(QT_F32);
        repeat (4) send_block(QT_F32);

        drain();
        repeat (60) @(negedge i_clk);
        $display("Sent %0d bytes through all ten formats and unknown codes, with restarts,",
                 bytes_sent);
        $display("stalls on both sides and a long output hold; %0d results checked.", results);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
